// ----- sv/pqc_pkg.sv -----
// shared constants, types and register codes of the predictive quality controller
// no dependencies
package pqc_pkg;

  localparam int WINDOW   = 20;
  localparam int MIN_FILL = 5;
  localparam int SLOT_W   = $clog2(WINDOW);
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int SUM_W    = 16 + CNT_W;
  localparam int SQ_W     = 32 + CNT_W;
  localparam int D_W      = SQ_W + CNT_W;
  localparam int DIVN_W   = 66;
  localparam int DIVD_W   = 49;
  localparam int DIVC_W   = 7;
  localparam logic [D_W-1:0] DEN_FLOOR = D_W'(1074);

  typedef enum logic [2:0] {
    REG_TARGET  = 3'd0,
    REG_MIN_R   = 3'd1,
    REG_MAX_R   = 3'd2,
    REG_MIN_L   = 3'd3,
    REG_MAX_L   = 3'd4,
    REG_GAIN    = 3'd5,
    REG_PRED_ON = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;  // left aligned, nbits significant bits
    logic [DIVD_W-1:0] divisor;
    logic [DIVC_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [DIVN_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- sv/pqc_ram.sv -----
// window memory: one entry per held pair, rate in low half, level in high half
// depends on pqc_pkg
module pqc_ram
  import pqc_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  logic [31:0]       wdata,
  input  logic [SLOT_W-1:0] raddr,
  output logic [31:0]       rdata
);

  logic [31:0] mem [WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/pqc_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on pqc_pkg
module pqc_div
  import pqc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIVN_W-1:0] num;
  logic [DIVD_W-1:0] den;
  logic [DIVD_W-1:0] rem;
  logic [DIVN_W-1:0] quo;
  logic [DIVC_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [DIVD_W:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem, num[DIVN_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        num  <= req.dividend;
        den  <= req.divisor;
        rem  <= '0;
        quo  <= '0;
        cnt  <= req.nbits;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? DIVD_W'(rem_sh - {1'b0, den}) : rem_sh[DIVD_W-1:0];
        quo <= {quo[DIVN_W-2:0], ge};
        num <= {num[DIVN_W-2:0], 1'b0};
        cnt <= cnt - DIVC_W'(1);
        if (cnt == DIVC_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.busy     = busy;
  assign rsp.quotient = quo;

endmodule

// ----- sv/predictive_quality_controller.sv -----
// top level of the predictive quality controller
// depends on pqc_pkg, pqc_ram, pqc_div
//
// Takes one request at a time: a measured rate (Q8.8) and the quality level it was
// measured at (Q1.15). The pair is written into a 20-entry window memory while running
// sums of rate, level, rate*level and level^2 are updated from the entry it replaces.
// In predictive mode a least-squares line of rate over level gives the expected rate
// at the given level (target when fewer than 5 pairs are held or the levels are flat),
// and the relative rate error, weighted by gain, pulls the level, which is clamped and
// blended 0.3/0.7 with the held level. Reactive mode steps the held level by 0.95 or
// 1.02. Predictive mode uses the shared bit-serial divider, for 66 quotient bits in the
// prediction and 38 in the level step. The blend and the reactive steps divide by
// constants through reciprocal multiplication. No clearing pass is needed after reset:
// window entries are read only once written. A finished result waits in the output
// register while the next request is taken.
module predictive_quality_controller
  import pqc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] measured_rate, [31:16] given_level
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] new_level, [31:16] predicted_rate
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_OLD, S_D1, S_D2, S_D3, S_M, S_N, S_W1,
    S_L1, S_L2, S_W2, S_H, S_W3, S_RW, S_OUT
  } state_t;

  // reciprocals for the constant divisions
  localparam logic [19:0] RECIP10  = 20'd838861;    // ceil(2^23 / 10)
  localparam logic [23:0] RECIP100 = 24'd10737419;  // ceil(2^30 / 100)

  // configuration registers
  logic [15:0] target_rate, min_rate, max_rate, min_level, max_level, gain;
  logic        predictive_on;

  // window bookkeeping and running sums
  logic [SLOT_W-1:0] write_slot;
  logic [CNT_W-1:0]  fill_count;
  logic [SUM_W-1:0]  sum_level, sum_rate;
  logic [SQ_W-1:0]   sum_product, sum_level_squared;
  logic [15:0]       held_level;

  // per-request working registers
  state_t            state;
  logic [15:0]       m_in, q_in, t_eff, pred, c_val;
  logic [D_W-1:0]    nsxx, sx2, dsc, a_v, b_v, nn;
  logic [SUM_W-1:0]  nq, mm;
  logic              nneg, mneg;
  logic [63:0]       t1, t2;
  logic [47:0]       nd;
  logic [31:0]       qt;
  logic signed [33:0] gd;
  logic [19:0]       blend_r;
  logic [22:0]       rv;
  logic [15:0]       out_level, out_pred;
  logic              out_valid;

  // memory and divider
  logic [31:0] rdata;
  logic        ram_we;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic accept;
  logic out_load;
  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign ram_we    = (state == S_OLD);
  assign out_load  = (state == S_OUT) && (!out_valid || m_tready);

  pqc_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata ({q_in, m_in}),
    .raddr (write_slot),
    .rdata (rdata)
  );

  pqc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // clamp with lower bound tested first, as the crossed-limit case needs
  function automatic logic [15:0] clamp66(input logic [DIVN_W-1:0] v,
                                          input logic [15:0] lo, input logic [15:0] hi);
    logic [15:0] r;
    if (v < DIVN_W'(lo)) r = lo;
    else if (v > DIVN_W'(hi)) r = hi;
    else r = v[15:0];
    return r;
  endfunction

  // sum updates when the new pair enters
  logic              full;
  logic [15:0]       orate, olev;
  logic [31:0]       p_new, p_old, q2_new, q2_old;
  assign full   = (fill_count >= CNT_W'(WINDOW));
  assign orate  = rdata[15:0];
  assign olev   = rdata[31:16];
  assign p_new  = m_in * q_in;
  assign q2_new = q_in * q_in;
  assign p_old  = full ? orate * olev : 32'd0;
  assign q2_old = full ? olev * olev : 32'd0;

  // combined numerator of the prediction
  logic        sub_case, neg_num;
  logic [63:0] num;
  logic [65:0] twice;
  assign sub_case = (nneg != mneg) && (nn != '0) && (mm != '0);
  assign neg_num  = sub_case && (t1 < t2);
  assign num      = sub_case ? t1 - t2 : t1 + t2;
  assign twice    = {1'b0, num, 1'b0} + 66'(nd);

  // level step numerator: 2x + 10T, signed
  logic signed [39:0] tval;
  logic [20:0]        t20;
  assign tval = $signed({4'b0, qt, 4'b0}) + $signed({6'b0, qt, 2'b0})
              + $signed({21'b0, t_eff, 3'b0}) + $signed({23'b0, t_eff, 1'b0})
              - $signed({{5{gd[33]}}, gd, 1'b0});
  assign t20  = {1'b0, t_eff, 4'b0} + {3'b0, t_eff, 2'b0};

  // blend numerator and its tenth
  logic [19:0] blend;
  logic [39:0] blend_prod;
  assign blend      = 20'(c_val) * 20'd3 + 20'(held_level) * 20'd7 + 20'd5;
  assign blend_prod = 40'(blend_r) * 40'(RECIP10);

  // reactive step numerator and its hundredth (up to 17 bits)
  logic slow, fast;
  logic [22:0] down_v, up_v;
  logic [46:0] rv_prod;
  logic [16:0] rv_q;
  assign slow    = (19'(m_in) * 19'd5) < (19'(t_eff) * 19'd4);
  assign fast    = (20'(m_in) * 20'd10) > (20'(t_eff) * 20'd11);
  assign down_v  = 23'(held_level) * 23'd95 + 23'd50;
  assign up_v    = 23'(held_level) * 23'd102 + 23'd50;
  assign rv_prod = 47'(rv) * 47'(RECIP100);
  assign rv_q    = rv_prod[46:30];

  logic signed [16:0] perr;
  assign perr = $signed({1'b0, pred}) - $signed({1'b0, t_eff});

  always_ff @(posedge clk) begin
    if (rst) begin
      target_rate       <= 16'd7680;
      min_rate          <= 16'd3840;
      max_rate          <= 16'd15360;
      min_level         <= 16'd9830;
      max_level         <= 16'd32768;
      gain              <= 16'd16384;
      predictive_on     <= 1'b1;
      write_slot        <= '0;
      fill_count        <= '0;
      sum_level         <= '0;
      sum_rate          <= '0;
      sum_product       <= '0;
      sum_level_squared <= '0;
      held_level        <= 16'd32768;
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      dreq.start        <= 1'b0;
    end else begin
      if (out_load) begin
        out_level <= held_level;
        out_pred  <= pred;
        out_valid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET:  target_rate   <= cfg_data;
          REG_MIN_R:   min_rate      <= cfg_data;
          REG_MAX_R:   max_rate      <= cfg_data;
          REG_MIN_L:   min_level     <= cfg_data;
          REG_MAX_L:   max_level     <= cfg_data;
          REG_GAIN:    gain          <= cfg_data;
          REG_PRED_ON: predictive_on <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            m_in  <= s_tdata[15:0];
            q_in  <= s_tdata[31:16];
            t_eff <= (target_rate == 16'd0) ? 16'd1 : target_rate;
            state <= S_OLD;
          end
        end
        S_OLD: begin
          // old entry is on the read port now, replace it
          sum_rate          <= sum_rate - (full ? SUM_W'(orate) : '0) + SUM_W'(m_in);
          sum_level         <= sum_level - (full ? SUM_W'(olev) : '0) + SUM_W'(q_in);
          sum_product       <= sum_product - SQ_W'(p_old) + SQ_W'(p_new);
          sum_level_squared <= sum_level_squared - SQ_W'(q2_old) + SQ_W'(q2_new);
          if (!full) fill_count <= fill_count + CNT_W'(1);
          write_slot <= (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + SLOT_W'(1);
          pred <= t_eff;
          if (predictive_on) begin
            state <= S_D1;
          end else if (slow) begin
            rv    <= down_v;
            state <= S_RW;
          end else if (fast) begin
            rv    <= up_v;
            state <= S_RW;
          end else begin
            state <= S_OUT;
          end
        end
        S_D1: begin
          nsxx  <= D_W'(fill_count) * D_W'(sum_level_squared);
          sx2   <= D_W'(sum_level) * D_W'(sum_level);
          state <= S_D2;
        end
        S_D2: begin
          dsc   <= nsxx - sx2;
          a_v   <= D_W'(fill_count) * D_W'(sum_product);
          b_v   <= D_W'(sum_level) * D_W'(sum_rate);
          nq    <= SUM_W'(fill_count) * SUM_W'(q_in);
          state <= S_D3;
        end
        S_D3: begin
          nneg <= a_v < b_v;
          nn   <= (a_v < b_v) ? b_v - a_v : a_v - b_v;
          mneg <= nq < sum_level;
          mm   <= (nq < sum_level) ? sum_level - nq : nq - sum_level;
          // short history or flat levels keep the target
          if (fill_count < CNT_W'(MIN_FILL) || dsc < DEN_FLOOR) state <= S_L1;
          else state <= S_M;
        end
        S_M: begin
          t1    <= 64'(sum_rate) * 64'(dsc);
          t2    <= 64'(nn) * 64'(mm);
          nd    <= 48'(fill_count) * 48'(dsc);
          state <= S_N;
        end
        S_N: begin
          if (neg_num) begin
            pred  <= min_rate;
            state <= S_L1;
          end else begin
            dreq.dividend <= twice;
            dreq.divisor  <= DIVD_W'({nd, 1'b0});
            dreq.nbits    <= DIVC_W'(DIVN_W);
            dreq.start    <= 1'b1;
            state         <= S_W1;
          end
        end
        S_W1: begin
          dreq.start <= 1'b0;
          if (drsp.done) begin
            pred  <= clamp66(drsp.quotient, min_rate, max_rate);
            state <= S_L1;
          end
        end
        S_L1: begin
          qt    <= q_in * t_eff;
          gd    <= $signed({1'b0, gain}) * perr;
          state <= S_L2;
        end
        S_L2: begin
          if (tval[39]) begin
            // negative step value lands below any lower limit
            c_val <= min_level;
            state <= S_H;
          end else begin
            dreq.dividend <= {tval[37:0], 28'b0};
            dreq.divisor  <= DIVD_W'(t20);
            dreq.nbits    <= DIVC_W'(38);
            dreq.start    <= 1'b1;
            state         <= S_W2;
          end
        end
        S_W2: begin
          dreq.start <= 1'b0;
          if (drsp.done) begin
            c_val <= clamp66(drsp.quotient, min_level, max_level);
            state <= S_H;
          end
        end
        S_H: begin
          blend_r <= blend;
          state   <= S_W3;
        end
        S_W3: begin
          // floor of the blend over ten
          held_level <= blend_prod[38:23];
          state      <= S_OUT;
        end
        S_RW: begin
          if (slow) begin
            held_level <= (rv_q < {1'b0, min_level}) ? min_level : rv_q[15:0];
          end else begin
            held_level <= (rv_q > {1'b0, max_level}) ? max_level : rv_q[15:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // wait for the output register to be free
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_pred, out_level};

  // window bookkeeping never leaves its range
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    write_slot < SLOT_W'(WINDOW))
    else $error("write slot beyond window");

  // the divider is never restarted while it is still working
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> !drsp.busy)
    else $error("divider restarted while busy");

  // the window is written only for an accepted request
  a_write_once: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> $past(accept))
    else $error("window write without a request");

endmodule
